// File: design/xsa_pkg.sv
// Shared constants, types and constant matrix functions for the xorshift skip-ahead block.
`timescale 1ns / 1ps

package xsa_pkg;

    localparam int STATE_BITS_DEFAULT = 32;
    localparam int SKIP_BITS_DEFAULT  = 32;
    localparam int MAX_BITS           = 64;
    localparam int OUT_BITS           = 32;

    typedef enum logic
    {
        VARIANT_LRL = 1'b0,
        VARIANT_RLR = 1'b1
    } variant_t;

    typedef logic [MAX_BITS-1:0]               word_t;
    typedef logic [MAX_BITS-1:0][MAX_BITS-1:0] mat_t;

    function automatic word_t xsa_mask(input int nbits);
        word_t m;
        m = '1;
        if (nbits < MAX_BITS)
        begin
            m = (word_t'(1) << nbits) - word_t'(1);
        end
        return m;
    endfunction

    function automatic word_t xsa_gen_step(input word_t x_in, input variant_t variant,
                                           input int nbits);
        word_t m;
        word_t x;
        m = xsa_mask(nbits);
        x = x_in & m;
        if (variant == VARIANT_LRL)
        begin
            x = x ^ ((x << 13) & m);
            x = x ^ (x >> 17);
            x = x ^ ((x << 5) & m);
        end
        else
        begin
            x = x ^ (x >> 11);
            x = x ^ ((x << 13) & m);
            x = x & (m >> 1);
            x = x ^ (x >> 20);
        end
        return x & m;
    endfunction

    function automatic word_t xsa_apply(input mat_t col, input word_t v, input int nbits);
        word_t y;
        y = '0;
        for (int i = 0; i < nbits; i++)
        begin
            if (v[i])
            begin
                y = y ^ col[i];
            end
        end
        return y;
    endfunction

    // Column j of the result is the image of unit vector j under M^(2^pow_log).
    function automatic mat_t xsa_mat_pow(input variant_t variant, input int nbits,
                                         input int pow_log);
        mat_t col;
        mat_t tmp;
        col = '0;
        tmp = '0;
        for (int j = 0; j < nbits; j++)
        begin
            col[j] = xsa_gen_step(word_t'(1) << j, variant, nbits);
        end
        for (int p = 0; p < pow_log; p++)
        begin
            for (int j = 0; j < nbits; j++)
            begin
                tmp[j] = xsa_apply(col, col[j], nbits);
            end
            col = tmp;
        end
        return col;
    endfunction

endpackage

// File: design/xsa_stage.sv
// One pipeline stage: applies M^(2^IDX) to the state when skip bit IDX is set.
`timescale 1ns / 1ps

module xsa_stage #(
    parameter int STATE_BITS = xsa_pkg::STATE_BITS_DEFAULT,
    parameter int SKIP_BITS  = xsa_pkg::SKIP_BITS_DEFAULT,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xsa_pkg::variant_t     variant,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [STATE_BITS-1:0] in_state,
    input  logic [SKIP_BITS-1:0]  in_skip,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATE_BITS-1:0] out_state,
    output logic [SKIP_BITS-1:0]  out_skip
);
    import xsa_pkg::*;

    localparam mat_t MAT_LRL = xsa_mat_pow(VARIANT_LRL, STATE_BITS, IDX);
    localparam mat_t MAT_RLR = xsa_mat_pow(VARIANT_RLR, STATE_BITS, IDX);

    logic                  valid_reg;
    logic                  valid_next;
    logic [STATE_BITS-1:0] state_reg;
    logic [STATE_BITS-1:0] state_next;
    logic [SKIP_BITS-1:0]  skip_reg;
    logic [STATE_BITS-1:0] product;
    logic                  load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_skip  = skip_reg;

    always_comb
    begin
        product = '0;
        for (int j = 0; j < STATE_BITS; j++)
        begin
            if (in_state[j])
            begin
                if (variant == VARIANT_RLR)
                begin
                    product = product ^ MAT_RLR[j][STATE_BITS-1:0];
                end
                else
                begin
                    product = product ^ MAT_LRL[j][STATE_BITS-1:0];
                end
            end
        end
        state_next = in_skip[IDX] ? product : in_state;
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            state_reg <= state_next;
            skip_reg  <= in_skip;
        end
    end

endmodule

// File: design/xorshift_skip_ahead.sv
// Top level of the xorshift skip-ahead block: configuration register and stage chain.
`timescale 1ns / 1ps

// Advances a xorshift state by skip_count steps as M^k times x over GF(2), one register
// stage per skip-count bit, each stage holding the constant matrix M^(2^i) for both
// generator variants. A new request is taken every cycle unless the output stalls.
// A request passes through SKIP_BITS registers before its result is offered on m_tdata.
// Each stage has its own valid bit and the ready chain lets bubbles close, so a stalled
// output only holds the stages that are full. The generator variant register must be
// written while no request is in flight.
module xorshift_skip_ahead #(
    parameter int STATE_BITS = xsa_pkg::STATE_BITS_DEFAULT,
    parameter int SKIP_BITS  = xsa_pkg::SKIP_BITS_DEFAULT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic                                          cfg_data,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // Fields from bit 0: start_state, skip_count, zero fill.
    input  logic [((STATE_BITS+SKIP_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // Fields from bit 0: advanced_state.
    output logic [xsa_pkg::OUT_BITS-1:0]                  m_tdata
);
    import xsa_pkg::*;

    variant_t variant_reg;

    logic [SKIP_BITS:0]                 vld;
    logic [SKIP_BITS:0]                 rdy;
    logic [SKIP_BITS:0][STATE_BITS-1:0] st;
    logic [SKIP_BITS:0][SKIP_BITS-1:0]  sk;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= VARIANT_LRL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            variant_reg <= variant_t'(cfg_data);
        end
    end

    assign vld[0]   = s_tvalid;
    assign s_tready = rdy[0];
    assign st[0]    = s_tdata[STATE_BITS-1:0];
    assign sk[0]    = s_tdata[STATE_BITS+SKIP_BITS-1:STATE_BITS];

    for (genvar i = 0; i < SKIP_BITS; i++)
    begin : g_stage
        xsa_stage #(
            .STATE_BITS(STATE_BITS),
            .SKIP_BITS (SKIP_BITS),
            .IDX       (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .variant  (variant_reg),
            .in_valid (vld[i]),
            .in_ready (rdy[i]),
            .in_state (st[i]),
            .in_skip  (sk[i]),
            .out_valid(vld[i+1]),
            .out_ready(rdy[i+1]),
            .out_state(st[i+1]),
            .out_skip (sk[i+1])
        );
    end

    assign m_tvalid       = vld[SKIP_BITS];
    assign rdy[SKIP_BITS] = m_tready;

    if (STATE_BITS >= OUT_BITS)
    begin : g_out_trunc
        assign m_tdata = st[SKIP_BITS][OUT_BITS-1:0];
    end
    else
    begin : g_out_ext
        assign m_tdata = {{(OUT_BITS-STATE_BITS){1'b0}}, st[SKIP_BITS]};
    end

endmodule

// File: design/xsa_checker.sv
// Port-level assertions for the xorshift skip-ahead block and their bind statement.
`timescale 1ns / 1ps

module xsa_checker #(
    parameter int STATE_BITS = xsa_pkg::STATE_BITS_DEFAULT,
    parameter int SKIP_BITS  = xsa_pkg::SKIP_BITS_DEFAULT
) (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      s_tvalid,
    input logic                                      s_tready,
    input logic [((STATE_BITS+SKIP_BITS+7)/8)*8-1:0] s_tdata,
    input logic                                      m_tvalid,
    input logic                                      m_tready,
    input logic [xsa_pkg::OUT_BITS-1:0]              m_tdata
);
    import xsa_pkg::*;

    // A request that is not taken stays offered with the same value.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("request changed while stalled");

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // With the last stage empty every stage can move, so a request is taken.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled behind an empty output");

    // An open output leaves no stage blocked.
    a_flow_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

endmodule

bind xorshift_skip_ahead xsa_checker #(
    .STATE_BITS(STATE_BITS),
    .SKIP_BITS (SKIP_BITS)
) u_xsa_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// File: tb/tb_xorshift_skip_ahead.sv
// Testbench for the xorshift skip-ahead block: directed and random jumps for both generators.
`timescale 1ns / 1ps

module tb_xorshift_skip_ahead;

    import xsa_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int FLUSH_CYCLES = 40;
    localparam int PHASE_ITEMS  = 210;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // Fields from bit 0: start_state, skip_count.
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // Fields from bit 0: advanced_state.
    logic [31:0] m_tdata;

    // jump_cols[v][i][j] is the image of unit vector j after 2^i steps of generator v.
    bit [31:0][31:0] jump_cols [0:1][0:31];
    variant_t        variant_model = VARIANT_LRL;
    bit [31:0]       advanced_q [$];
    bit [31:0]       want_state;
    int              errors       = 0;
    int              idle_cycles  = 0;
    bit              sender_idles = 1'b1;
    bit              sink_stalls  = 1'b1;

    xorshift_skip_ahead i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic bit [31:0] single_step(input int v, input bit [31:0] x_in);
        bit [31:0] x;
        x = x_in;
        if (v == int'(VARIANT_LRL))
        begin
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
        end
        else
        begin
            x = x ^ (x >> 11);
            x = x ^ (x << 13);
            x = x & 32'h7fff_ffff;
            x = x ^ (x >> 20);
        end
        return x;
    endfunction

    function automatic bit [31:0] mat_times_vec(input bit [31:0][31:0] cols, input bit [31:0] v);
        bit [31:0] y;
        y = '0;
        for (int j = 0; j < 32; j++)
        begin
            if (v[j])
            begin
                y = y ^ cols[j];
            end
        end
        return y;
    endfunction

    task automatic build_jump_tables();
        for (int v = 0; v < 2; v++)
        begin
            for (int j = 0; j < 32; j++)
            begin
                jump_cols[v][0][j] = single_step(v, 32'd1 << j);
            end
            for (int p = 1; p < 32; p++)
            begin
                for (int j = 0; j < 32; j++)
                begin
                    jump_cols[v][p][j] = mat_times_vec(jump_cols[v][p-1], jump_cols[v][p-1][j]);
                end
            end
        end
    endtask

    function automatic bit [31:0] advance_state(input variant_t v, input bit [31:0] state,
                                                input bit [31:0] skip);
        bit [31:0] y;
        y = state;
        for (int i = 0; i < 32; i++)
        begin
            if (skip[i])
            begin
                y = mat_times_vec(jump_cols[int'(v)][i], y);
            end
        end
        return y;
    endfunction

    task automatic send_request(input bit [31:0] state, input bit [31:0] skip);
        int gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {skip, state};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        advanced_q.push_back(advance_state(variant_model, state, skip));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (advanced_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_variant(input variant_t v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid     <= 1'b0;
        variant_model  = v;
    endtask

    function automatic bit [31:0] random_state();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000 | $urandom;
            3:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] random_skip();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom_range(0, 64);
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return 32'hffff_ffff;
            4:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_lrl_directed();
        write_variant(VARIANT_LRL);
        send_request(32'h0000_0001, 32'd0);
        send_request(32'h0000_0001, 32'd1);
        send_request(32'h0000_0001, 32'd2);
        send_request(32'h0000_0000, 32'hffff_ffff);
        send_request(32'h0000_0000, 32'h1234_5678);
        send_request(32'hffff_ffff, 32'd0);
        send_request(32'hffff_ffff, 32'hffff_ffff);
        send_request(32'h8000_0000, 32'd1);
        send_request(32'h1234_5678, 32'h8000_0000);
        send_request(32'hdead_beef, 32'h5555_aaaa);
    endtask

    task automatic test_rlr_directed();
        write_variant(VARIANT_RLR);
        // A set top bit must survive a zero skip and feed only the first step otherwise.
        send_request(32'h8000_0000, 32'd0);
        send_request(32'hffff_ffff, 32'd0);
        send_request(32'h8000_0000, 32'd1);
        send_request(32'hffff_ffff, 32'd1);
        send_request(32'hffff_ffff, 32'hffff_ffff);
        send_request(32'h7fff_ffff, 32'h7fff_ffff);
        send_request(32'h0000_0000, 32'hffff_ffff);
        send_request(32'h0000_0001, 32'd1);
        send_request(32'h0000_0001, 32'h8000_0000);
        send_request(32'h0000_0001, 32'd3);
        send_request(32'hcafe_f00d, 32'h0001_0000);
        send_request(32'h1357_9bdf, 32'haaaa_5555);
    endtask

    task automatic test_pause_until_drained();
        for (int burst = 0; burst < 3; burst++)
        begin
            for (int n = 0; n < 16; n++)
            begin
                send_request(random_state(), random_skip());
            end
            wait_drained();
        end
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_variant(variant_t'(phase[0] ^ phase[2]));
            sender_idles = (phase % 4 == 0) || (phase % 4 == 2);
            sink_stalls  = (phase % 4 == 0) || (phase % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_request(random_state(), random_skip());
            end
        end
        sender_idles = 1'b1;
        sink_stalls  = 1'b1;
    endtask

    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = sink_stalls ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (advanced_q.size() == 0)
            begin
                $display("%0t: unexpected advanced_state: expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                want_state = advanced_q.pop_front();
                if (m_tdata !== want_state)
                begin
                    $display("%0t: advanced_state mismatch: expected %h, actual %h",
                             $time, want_state, m_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        build_jump_tables();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lrl_directed();
        test_rlr_directed();
        test_pause_until_drained();
        test_random_phases();
        wait_drained();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
